// ===== src/bpec_pkg.sv =====
// ----------------------------------------------------------------------------
// bpec_pkg
// Shared constants, codes and types of the Boolean product error counter.
// ----------------------------------------------------------------------------
package bpec_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int MAX_BASIS   = 16;

    localparam int IDX_W   = $clog2(MAX_BASIS);
    localparam int COLS_W  = 6;
    localparam int BASIS_W = 5;
    localparam int ERR_W   = 32;
    localparam int TOTAL_W = 64;
    localparam int CFG_W   = 6;
    localparam int ADDR_W  = 2;

    // popcount of one row: result width and number of byte groups
    localparam int PC_W   = $clog2(MAX_COLUMNS + 1);
    localparam int NBYTES = (MAX_COLUMNS + 7) / 8;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_RAW = IDX_W + MAX_COLUMNS + MAX_BASIS;
    localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
    localparam int M_DATA_W   = ERR_W + TOTAL_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SCORE = 1'b1
    } opcode_t;

    typedef enum logic {
        MODE_UNIFORM = 1'b0,
        MODE_BINARY  = 1'b1
    } err_mode_t;

    typedef enum logic [ADDR_W-1:0] {
        REG_ERROR_MODE     = 2'd0,
        REG_COLUMNS_IN_USE = 2'd1,
        REG_BASIS_IN_USE   = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_index_t;

    // classified request handed from the front end to the back end
    typedef struct packed {
        opcode_t                opcode;
        logic [IDX_W-1:0]       basis_index;
        logic [MAX_COLUMNS-1:0] row_bits;
        logic [MAX_BASIS-1:0]   usage_bits;
        logic                   last_row;
    } item_t;

    typedef struct packed {
        err_mode_t         error_mode;
        logic [COLS_W-1:0] columns_in_use;
    } back_cfg_t;

endpackage

// ===== src/boolean_product_error_count_unit.sv =====
// ----------------------------------------------------------------------------
// boolean_product_error_count_unit
// Loads basis rows and scores target rows of a Boolean matrix factorization.
// ----------------------------------------------------------------------------
// Path: an accepted request passes from its queue slot through the error stage
//   to the output register, which drives m_tvalid.
// Throughput: one request per cycle while m_tready does not stall the output.
// Reset clears the running total, the clip flag, the queue and the pipeline,
//   and restores error_mode=uniform, columns_in_use=32, basis_in_use=16.
// The basis rows are not cleared; a row is valid once loaded.
module boolean_product_error_count_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [bpec_pkg::ADDR_W-1:0]       cfg_addr,
    input  logic [bpec_pkg::CFG_W-1:0]        cfg_wdata,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bpec_pkg::S_DATA_W-1:0]     s_tdata,  // basis_index, row_bits, usage_bits
    input  logic                              s_tuser,  // opcode
    input  logic                              s_tlast,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bpec_pkg::M_DATA_W-1:0]     m_tdata,  // row_error, total_error
    output logic                              m_tuser,  // saturated
    output logic                              m_tlast
);

    bpec_pkg::err_mode_t               error_mode_reg;
    logic [bpec_pkg::COLS_W-1:0]       columns_reg;
    logic [bpec_pkg::BASIS_W-1:0]      basis_reg;

    bpec_pkg::item_t                   front_item, q_item;
    bpec_pkg::back_cfg_t               back_cfg;
    logic                              q_valid, q_ready;
    logic [bpec_pkg::ERR_W-1:0]        row_error;
    logic [bpec_pkg::TOTAL_W-1:0]      total_error;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_mode_reg <= bpec_pkg::MODE_UNIFORM;
            columns_reg    <= bpec_pkg::COLS_W'(bpec_pkg::MAX_COLUMNS);
            basis_reg      <= bpec_pkg::BASIS_W'(bpec_pkg::MAX_BASIS);
        end else if (cfg_wr_en) begin
            case (bpec_pkg::reg_index_t'(cfg_addr))
                bpec_pkg::REG_ERROR_MODE: begin
                    error_mode_reg <= bpec_pkg::err_mode_t'(cfg_wdata[0]);
                end
                bpec_pkg::REG_COLUMNS_IN_USE: begin
                    columns_reg <= cfg_wdata[bpec_pkg::COLS_W-1:0];
                end
                bpec_pkg::REG_BASIS_IN_USE: begin
                    basis_reg <= cfg_wdata[bpec_pkg::BASIS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign back_cfg.error_mode     = error_mode_reg;
    assign back_cfg.columns_in_use = columns_reg;

    bpec_front u_front (
        .s_data       (s_tdata),
        .s_kind       (s_tuser),
        .s_last       (s_tlast),
        .basis_in_use (basis_reg),
        .item         (front_item)
    );

    bpec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    bpec_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (back_cfg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_row_error   (row_error),
        .m_total_error (total_error),
        .m_saturated   (m_tuser),
        .m_done        (m_tlast)
    );

    assign m_tdata = {total_error, row_error};

endmodule

// ===== src/bpec_front.sv =====
// ----------------------------------------------------------------------------
// bpec_front
// Unpacks an input request and classifies it; score requests get their
// usage bits trimmed to the basis rows in use.
// ----------------------------------------------------------------------------
module bpec_front (
    input  logic [bpec_pkg::S_DATA_W-1:0] s_data,
    input  logic                          s_kind,
    input  logic                          s_last,
    input  logic [bpec_pkg::BASIS_W-1:0]  basis_in_use,
    output bpec_pkg::item_t               item
);

    logic [bpec_pkg::MAX_BASIS-1:0] usage_mask;
    logic [bpec_pkg::MAX_BASIS-1:0] usage_raw;

    always_comb begin
        if (basis_in_use >= bpec_pkg::BASIS_W'(bpec_pkg::MAX_BASIS)) begin
            usage_mask = '1;
        end else begin
            usage_mask = (bpec_pkg::MAX_BASIS'(1) << basis_in_use)
                         - bpec_pkg::MAX_BASIS'(1);
        end
    end

    assign usage_raw = s_data[bpec_pkg::IDX_W + bpec_pkg::MAX_COLUMNS +: bpec_pkg::MAX_BASIS];

    always_comb begin
        item.opcode      = bpec_pkg::opcode_t'(s_kind);
        item.basis_index = s_data[bpec_pkg::IDX_W-1:0];
        item.row_bits    = s_data[bpec_pkg::IDX_W +: bpec_pkg::MAX_COLUMNS];
        item.last_row    = s_last;
        // loads ignore usage bits
        if (item.opcode == bpec_pkg::OP_SCORE) begin
            item.usage_bits = usage_raw & usage_mask;
        end else begin
            item.usage_bits = '0;
        end
    end

endmodule

// ===== src/bpec_queue.sv =====
// ----------------------------------------------------------------------------
// bpec_queue
// Small FIFO of classified requests between front end and back end.
// ----------------------------------------------------------------------------
module bpec_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bpec_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output bpec_pkg::item_t out_item
);

    bpec_pkg::item_t                  slot_reg [bpec_pkg::QUEUE_DEPTH];
    logic [bpec_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [bpec_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [bpec_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             push, pop;

    assign in_ready  = (count_reg != bpec_pkg::QCNT_W'(bpec_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == bpec_pkg::QPTR_W'(bpec_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + bpec_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == bpec_pkg::QPTR_W'(bpec_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + bpec_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + bpec_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - bpec_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== src/bpec_back.sv =====
// ----------------------------------------------------------------------------
// bpec_back
// Holds the basis rows, forms the product row and row error, then adds
// the error into the saturating running total behind an output register.
// ----------------------------------------------------------------------------
module bpec_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bpec_pkg::back_cfg_t             cfg,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  bpec_pkg::item_t                 q_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bpec_pkg::ERR_W-1:0]      m_row_error,
    output logic [bpec_pkg::TOTAL_W-1:0]    m_total_error,
    output logic                            m_saturated,
    output logic                            m_done
);

    function automatic logic [bpec_pkg::PC_W-1:0] pop_count(
        input logic [bpec_pkg::MAX_COLUMNS-1:0] v
    );
        logic [bpec_pkg::NBYTES*8-1:0] padded;
        logic [3:0]                    part;
        logic [bpec_pkg::PC_W-1:0]     acc;
        padded = (bpec_pkg::NBYTES*8)'(v);
        acc    = '0;
        for (int b = 0; b < bpec_pkg::NBYTES; b++) begin
            part = '0;
            for (int i = 0; i < 8; i++) begin
                part = part + 4'(padded[b*8 + i]);
            end
            acc = acc + bpec_pkg::PC_W'(part);
        end
        return acc;
    endfunction

    logic [bpec_pkg::MAX_COLUMNS-1:0] basis_reg [bpec_pkg::MAX_BASIS];

    // error stage
    logic                             mid_valid_reg;
    logic                             mid_load_reg;
    logic                             mid_last_reg;
    logic [bpec_pkg::ERR_W-1:0]       mid_err_reg;
    logic [bpec_pkg::ERR_W-1:0]       mid_err_next;

    // accumulate / output stage
    logic                             out_valid_reg;
    logic [bpec_pkg::ERR_W-1:0]       out_err_reg;
    logic [bpec_pkg::TOTAL_W-1:0]     out_total_reg;
    logic                             out_sat_reg;
    logic                             out_done_reg;
    logic [bpec_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic                             clip_reg, clip_next;

    logic                             mid_adv, pop;
    logic [bpec_pkg::MAX_COLUMNS-1:0] product, diff, col_mask;
    logic [bpec_pkg::TOTAL_W:0]       sum;
    logic [bpec_pkg::TOTAL_W-1:0]     sum_sat;
    logic                             sum_clip;

    assign mid_adv = mid_valid_reg && (!out_valid_reg || m_ready);
    assign q_ready = !mid_valid_reg || mid_adv;
    assign pop     = q_valid && q_ready;

    always_comb begin
        product = '0;
        for (int l = 0; l < bpec_pkg::MAX_BASIS; l++) begin
            if (q_item.usage_bits[l]) begin
                product = product | basis_reg[l];
            end
        end
    end

    always_comb begin
        if (cfg.columns_in_use >= bpec_pkg::COLS_W'(bpec_pkg::MAX_COLUMNS)) begin
            col_mask = '1;
        end else begin
            col_mask = (bpec_pkg::MAX_COLUMNS'(1) << cfg.columns_in_use)
                       - bpec_pkg::MAX_COLUMNS'(1);
        end
    end

    assign diff = (q_item.row_bits ^ product) & col_mask;

    always_comb begin
        if (q_item.opcode == bpec_pkg::OP_LOAD) begin
            mid_err_next = '0;
        end else if (cfg.error_mode == bpec_pkg::MODE_BINARY) begin
            mid_err_next = bpec_pkg::ERR_W'(diff);
        end else begin
            mid_err_next = bpec_pkg::ERR_W'(pop_count(diff));
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_item.opcode == bpec_pkg::OP_LOAD) begin
            basis_reg[q_item.basis_index] <= q_item.row_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (q_ready) begin
            mid_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            mid_load_reg <= (q_item.opcode == bpec_pkg::OP_LOAD);
            mid_last_reg <= q_item.last_row;
            mid_err_reg  <= mid_err_next;
        end
    end

    // saturating add of the row error into the running total
    assign sum      = {1'b0, total_reg} + (bpec_pkg::TOTAL_W + 1)'(mid_err_reg);
    assign sum_sat  = sum[bpec_pkg::TOTAL_W] ? '1 : sum[bpec_pkg::TOTAL_W-1:0];
    assign sum_clip = clip_reg || sum[bpec_pkg::TOTAL_W];

    always_comb begin
        total_next = total_reg;
        clip_next  = clip_reg;
        if (mid_adv) begin
            if (mid_last_reg && !mid_load_reg) begin
                total_next = '0;
                clip_next  = 1'b0;
            end else begin
                total_next = sum_sat;
                clip_next  = sum_clip;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            total_reg <= total_next;
            clip_reg  <= clip_next;
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_adv) begin
            out_err_reg   <= mid_err_reg;
            out_total_reg <= sum_sat;
            out_sat_reg   <= sum_clip;
            out_done_reg  <= mid_last_reg && !mid_load_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_row_error   = out_err_reg;
    assign m_total_error = out_total_reg;
    assign m_saturated   = out_sat_reg;
    assign m_done        = out_done_reg;

endmodule

// ===== verif/boolean_product_error_count_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boolean_product_error_count_checker
// Tracks configuration writes and accepted requests, predicts every row
// score and compares the result stream against it, field by field.
// ----------------------------------------------------------------------------
module boolean_product_error_count_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bpec_pkg::ADDR_W-1:0]     cfg_addr,
    input  logic [bpec_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bpec_pkg::S_DATA_W-1:0]   s_tdata,  // basis_index, row_bits, usage_bits
    input  logic                            s_tuser,  // opcode
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bpec_pkg::M_DATA_W-1:0]   m_tdata,  // row_error, total_error
    input  logic                            m_tuser,  // saturated
    input  logic                            m_tlast,
    output int                              mismatches,
    output int                              pending
);

    typedef struct packed {
        logic [bpec_pkg::ERR_W-1:0]   row_error;
        logic [bpec_pkg::TOTAL_W-1:0] total_error;
        logic                         saturated;
        logic                         done_res;
    } row_score_t;

    logic [bpec_pkg::MAX_COLUMNS-1:0] basis_rows [bpec_pkg::MAX_BASIS];
    logic [bpec_pkg::TOTAL_W-1:0]     running_total;
    logic                             clip_seen;
    bpec_pkg::err_mode_t              mode_q;
    logic [bpec_pkg::COLS_W-1:0]      cols_q;
    logic [bpec_pkg::BASIS_W-1:0]     basis_q;
    row_score_t                       expected_scores [$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    // updates the basis store and running total as the block would
    function automatic row_score_t score_request(bpec_pkg::item_t req);
        row_score_t                       res;
        logic [bpec_pkg::MAX_COLUMNS-1:0] product;
        logic [bpec_pkg::MAX_COLUMNS-1:0] diff;
        logic [bpec_pkg::MAX_COLUMNS-1:0] col_mask;
        logic [bpec_pkg::TOTAL_W:0]       sum;
        int                               m;
        int                               k;
        res = '0;
        if (req.opcode == bpec_pkg::OP_LOAD) begin
            basis_rows[req.basis_index] = req.row_bits;
            res.total_error = running_total;
            res.saturated   = clip_seen;
            return res;
        end
        m = int'(cols_q);
        if (m > bpec_pkg::MAX_COLUMNS) m = bpec_pkg::MAX_COLUMNS;
        k = int'(basis_q);
        if (k > bpec_pkg::MAX_BASIS) k = bpec_pkg::MAX_BASIS;
        product = '0;
        for (int l = 0; l < k; l++) begin
            if (req.usage_bits[l]) product |= basis_rows[l];
        end
        // used columns are the low m bits; m = 0 leaves nothing
        col_mask = {bpec_pkg::MAX_COLUMNS{1'b1}} >> (bpec_pkg::MAX_COLUMNS - m);
        diff = (req.row_bits ^ product) & col_mask;
        res.row_error = (mode_q == bpec_pkg::MODE_BINARY)
                        ? bpec_pkg::ERR_W'(diff)
                        : bpec_pkg::ERR_W'($countones(diff));
        sum = {1'b0, running_total} + (bpec_pkg::TOTAL_W + 1)'(res.row_error);
        res.saturated = clip_seen;
        if (sum[bpec_pkg::TOTAL_W]) begin
            res.total_error = '1;
            res.saturated   = 1'b1;
        end else begin
            res.total_error = sum[bpec_pkg::TOTAL_W-1:0];
        end
        res.done_res = req.last_row;
        if (req.last_row) begin
            running_total = '0;
            clip_seen     = 1'b0;
        end else begin
            running_total = res.total_error;
            clip_seen     = res.saturated;
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [bpec_pkg::TOTAL_W-1:0] want_v,
                               logic [bpec_pkg::TOTAL_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        bpec_pkg::item_t req;
        row_score_t      want;
        if (!aresetn) begin
            running_total = '0;
            clip_seen     = 1'b0;
            mode_q        = bpec_pkg::MODE_UNIFORM;
            cols_q        = bpec_pkg::COLS_W'(bpec_pkg::MAX_COLUMNS);
            basis_q       = bpec_pkg::BASIS_W'(bpec_pkg::MAX_BASIS);
            expected_scores.delete();
        end else begin
            if (cfg_wr_en) begin
                case (bpec_pkg::reg_index_t'(cfg_addr))
                    bpec_pkg::REG_ERROR_MODE:
                        mode_q = bpec_pkg::err_mode_t'(cfg_wdata[0]);
                    bpec_pkg::REG_COLUMNS_IN_USE:
                        cols_q = cfg_wdata[bpec_pkg::COLS_W-1:0];
                    bpec_pkg::REG_BASIS_IN_USE:
                        basis_q = cfg_wdata[bpec_pkg::BASIS_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_scores.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_scores.pop_front();
                    check_field("row_error",
                                bpec_pkg::TOTAL_W'(want.row_error),
                                bpec_pkg::TOTAL_W'(m_tdata[bpec_pkg::ERR_W-1:0]));
                    check_field("total_error", want.total_error,
                                m_tdata[bpec_pkg::ERR_W +: bpec_pkg::TOTAL_W]);
                    check_field("saturated", bpec_pkg::TOTAL_W'(want.saturated),
                                bpec_pkg::TOTAL_W'(m_tuser));
                    check_field("done_res", bpec_pkg::TOTAL_W'(want.done_res),
                                bpec_pkg::TOTAL_W'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) begin
                req.opcode      = bpec_pkg::opcode_t'(s_tuser);
                req.basis_index = s_tdata[bpec_pkg::IDX_W-1:0];
                req.row_bits    = s_tdata[bpec_pkg::IDX_W +: bpec_pkg::MAX_COLUMNS];
                req.usage_bits  = s_tdata[bpec_pkg::IDX_W + bpec_pkg::MAX_COLUMNS +:
                                          bpec_pkg::MAX_BASIS];
                req.last_row    = s_tlast;
                expected_scores.push_back(score_request(req));
            end
        end
        pending = expected_scores.size();
    end

endmodule

// ===== verif/boolean_product_error_count_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boolean_product_error_count_unit_tb
// Loads basis rows, scores target rows under several mode, column and basis
// settings with random gaps and stalls on both streams, and checks every
// result through the attached checker.
// ----------------------------------------------------------------------------
module boolean_product_error_count_unit_tb;

    localparam int STALL_LIMIT      = 5000;
    localparam int HOLD_CYCLES      = 300;
    localparam int PHASES           = 7;
    localparam int RANDOM_PER_PHASE = 68;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [bpec_pkg::ADDR_W-1:0]     cfg_addr;
    logic [bpec_pkg::CFG_W-1:0]      cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bpec_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            s_tuser;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bpec_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    int   mismatches;
    int   pending;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    int   idle_cycles  = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;

    boolean_product_error_count_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    boolean_product_error_count_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // result side; one long hold-off lets the block back up into its input
    initial begin
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(bpec_pkg::opcode_t op, logic [bpec_pkg::IDX_W-1:0] idx,
                                logic [bpec_pkg::MAX_COLUMNS-1:0] row,
                                logic [bpec_pkg::MAX_BASIS-1:0] usage, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= bpec_pkg::S_DATA_W'({usage, row, idx});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random_request();
        logic [bpec_pkg::MAX_COLUMNS-1:0] row;
        logic [bpec_pkg::MAX_BASIS-1:0]   usage;
        row = $urandom;
        case ($urandom_range(9))
            0: row = '0;
            1: row = '1;
            default: ;
        endcase
        usage = bpec_pkg::MAX_BASIS'($urandom);
        case ($urandom_range(9))
            0:       usage = '0;
            1:       usage = '1;
            2:       usage = bpec_pkg::MAX_BASIS'(1) << $urandom_range(bpec_pkg::MAX_BASIS - 1);
            3, 4:    usage = usage & bpec_pkg::MAX_BASIS'($urandom)
                                   & bpec_pkg::MAX_BASIS'($urandom);
            default: ;
        endcase
        if ($urandom_range(99) < 15)
            send_request(bpec_pkg::OP_LOAD, bpec_pkg::IDX_W'($urandom), row, usage,
                         1'($urandom_range(1)));
        else
            send_request(bpec_pkg::OP_SCORE, bpec_pkg::IDX_W'($urandom), row, usage,
                         $urandom_range(9) == 0);
    endtask

    task automatic write_config(bpec_pkg::reg_index_t idx,
                                logic [bpec_pkg::CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // upper bits beyond each register's width are random and must be dropped
    task automatic apply_settings(bpec_pkg::err_mode_t mode, int cols, int basis);
        write_config(bpec_pkg::REG_ERROR_MODE, {5'($urandom_range(31)), mode});
        write_config(bpec_pkg::REG_COLUMNS_IN_USE, bpec_pkg::CFG_W'(cols));
        write_config(bpec_pkg::REG_BASIS_IN_USE,
                     {1'($urandom_range(1)), bpec_pkg::BASIS_W'(basis)});
        write_config(bpec_pkg::REG_UNUSED, bpec_pkg::CFG_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        bpec_pkg::err_mode_t mode;
        int                  cols;
        int                  basis;
        int                  idle_mode;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= bpec_pkg::REG_ERROR_MODE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= bpec_pkg::OP_LOAD;
        s_tlast   <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole store first so no score ever reads an unloaded row
        for (int l = 0; l < bpec_pkg::MAX_BASIS; l++)
            send_request(bpec_pkg::OP_LOAD, bpec_pkg::IDX_W'(l),
                         (l == 0) ? 32'h0000_0000 : (l == 1) ? 32'hFFFF_FFFF :
                         (l == 2) ? 32'h8000_0001 : 32'($urandom),
                         bpec_pkg::MAX_BASIS'($urandom), 1'($urandom_range(1)));
        send_request(bpec_pkg::OP_SCORE, '0, '1, '0, 1'b0);         // empty product
        send_request(bpec_pkg::OP_SCORE, '0, '0, '1, 1'b0);         // all basis rows
        send_request(bpec_pkg::OP_SCORE, '0, '0, 16'h0001, 1'b0);   // zero row only
        send_request(bpec_pkg::OP_SCORE, '1, 32'h8000_0001, 16'h0004, 1'b1);
        wait_idle();

        for (int phase = 1; phase <= PHASES; phase++) begin
            case (phase)
                1: begin mode = bpec_pkg::MODE_BINARY;  cols = 32; basis = 16; end
                2: begin mode = bpec_pkg::MODE_UNIFORM; cols = 1;  basis = 1;  end
                3: begin mode = bpec_pkg::MODE_BINARY;  cols = 0;  basis = 0;  end
                4: begin mode = bpec_pkg::MODE_UNIFORM; cols = 63; basis = 31; end
                5: begin
                    mode  = bpec_pkg::MODE_BINARY;
                    cols  = $urandom_range(32, 1);
                    basis = $urandom_range(16, 1);
                end
                6: begin
                    mode  = bpec_pkg::MODE_UNIFORM;
                    cols  = $urandom_range(32, 1);
                    basis = $urandom_range(16, 1);
                end
                default: begin
                    mode  = bpec_pkg::MODE_BINARY;
                    cols  = $urandom_range(63, 33);
                    basis = $urandom_range(31, 17);
                end
            endcase
            apply_settings(mode, cols, basis);
            // 0: no gaps, 1: sender idles, 2: receiver stalls, 3: both
            idle_mode    = (phase * 3) % 4;
            tx_idle_pct  = (idle_mode == 1) ? 62 : (idle_mode == 3) ? 38 : 0;
            rx_stall_pct = (idle_mode == 2) ? 62 : (idle_mode == 3) ? 38 : 0;
            if (phase == 4) hold_req <= 1'b1;
            send_request(bpec_pkg::OP_SCORE, '0, '1, '0, 1'b0);
            repeat (RANDOM_PER_PHASE) send_random_request();
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
